// ===== rtl/cbr_pkg.sv =====
`default_nettype none
package cbr_pkg;

	// command codes of an input word
	localparam logic [1:0] CMD_ROBOT   = 2'd0;
	localparam logic [1:0] CMD_ADAPTER = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;

	// link event codes
	localparam logic [1:0] LINK_NONE     = 2'd0;
	localparam logic [1:0] LINK_DETECTED = 2'd1;
	localparam logic [1:0] LINK_LOST     = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_MASTER_BASE   = 3'd0;
	localparam logic [2:0] REG_SLAVE_BASE    = 3'd1;
	localparam logic [2:0] REG_LOCK_ID       = 3'd2;
	localparam logic [2:0] REG_ORDER_ID      = 3'd3;
	localparam logic [2:0] REG_HB_TIMEOUT    = 3'd4;
	localparam logic [2:0] REG_STABLE_THRESH = 3'd5;
	localparam logic [2:0] REG_HB_ENABLE     = 3'd6;

	// configuration reset values
	localparam logic [10:0] RST_MASTER_BASE   = 11'd292;
	localparam logic [10:0] RST_SLAVE_BASE    = 11'd266;
	localparam logic [10:0] RST_LOCK_ID       = 11'd137;
	localparam logic [10:0] RST_ORDER_ID      = 11'd368;
	localparam logic [3:0]  RST_HB_TIMEOUT    = 4'd10;
	localparam logic [4:0]  RST_STABLE_THRESH = 5'd20;
	localparam logic        RST_HB_ENABLE     = 1'b1;

	// bridge identifiers and masks
	localparam logic [10:0] BR_MASTER     = 11'h010;
	localparam logic [10:0] BR_SLAVE      = 11'h018;
	localparam logic [10:0] BR_LOCK       = 11'h020;
	localparam logic [10:0] BR_ORDER      = 11'h028;
	localparam logic [10:0] MASTER_MASK   = 11'h7FC;
	localparam logic [10:0] SLAVE_MASK    = 11'h7FE;
	localparam logic [10:0] BR_BLOCK_MASK = 11'h7F0;
	localparam logic [10:0] HB_MASTER_ID  = 11'h100;
	localparam logic [10:0] HB_SLAVE_ID   = 11'h101;
	localparam logic [3:0]  HB_DLC        = 4'h5;
	localparam logic [4:0]  STABLE_RELOAD = 5'd5;
	localparam logic [6:0]  LOST_MARGIN   = 7'd5;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [10:0] frame_id;
		logic [3:0]  frame_dlc;
		logic [7:0]  role_byte_master;
		logic [7:0]  role_byte_slave;
	} cbr_in_t;

	typedef struct packed {
		logic        send_valid;
		logic        out_port;
		logic [10:0] out_id;
		logic [3:0]  out_dlc;
		logic        hb_enabled;
		logic        hb_received;
		logic        hb_master;
		logic        hb_slave;
		logic [3:0]  hb_timeout;
		logic [1:0]  link_event;
	} cbr_out_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [10:0] value;
	} cbr_cfg_t;

	typedef struct packed {
		logic [10:0] master_robot_base;
		logic [10:0] slave_robot_base;
		logic [10:0] lock_order_robot_id;
		logic [10:0] order_robot_id;
		logic [3:0]  heartbeat_timeout;
		logic [4:0]  stable_threshold;
		logic        heartbeat_enable;
	} cbr_regs_t;

endpackage
`default_nettype wire

// ===== rtl/cbr_stream_if.sv =====
`default_nettype none
interface cbr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/can_bridge_id_remap_heartbeat_unit.sv =====
// CAN identifier bridge with peer heartbeat supervision. Every input word (robot
// frame, adapter frame or tick) yields exactly one result word, which carries a
// frame to send when send_valid is set. A word is taken every clock cycle unless the
// input register is full and a result waits untaken in the output register; a word
// sits in the input register, the filter match, id remap and link counters are
// evaluated in one pass, and the result lands in the output register, which offers it.
// The output register lets the next word in while a result waits to be taken.
// Configuration registers are written through the cfg channel, which is always
// ready, and must only change while idle.
`default_nettype none
module can_bridge_id_remap_heartbeat_unit (
	input wire logic clk,
	input wire logic arst_n,
	cbr_stream_if.sink   in_ch,
	cbr_stream_if.source out_ch,
	cbr_stream_if.sink   cfg
);

	cbr_pkg::cbr_regs_t regs_q;
	cbr_pkg::cbr_in_t   item_s1;
	logic               valid_s1;
	cbr_pkg::cbr_out_t  res;
	cbr_pkg::cbr_out_t  res_q;
	logic               out_valid_q;
	logic               advance;
	cbr_pkg::cbr_cfg_t  cfg_word;

	assign cfg_word = cfg.data;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.master_robot_base   <= cbr_pkg::RST_MASTER_BASE;
			regs_q.slave_robot_base    <= cbr_pkg::RST_SLAVE_BASE;
			regs_q.lock_order_robot_id <= cbr_pkg::RST_LOCK_ID;
			regs_q.order_robot_id      <= cbr_pkg::RST_ORDER_ID;
			regs_q.heartbeat_timeout   <= cbr_pkg::RST_HB_TIMEOUT;
			regs_q.stable_threshold    <= cbr_pkg::RST_STABLE_THRESH;
			regs_q.heartbeat_enable    <= cbr_pkg::RST_HB_ENABLE;
		end else if (cfg.valid) begin
			case (cfg_word.index)
				cbr_pkg::REG_MASTER_BASE:   regs_q.master_robot_base   <= cfg_word.value;
				cbr_pkg::REG_SLAVE_BASE:    regs_q.slave_robot_base    <= cfg_word.value;
				cbr_pkg::REG_LOCK_ID:       regs_q.lock_order_robot_id <= cfg_word.value;
				cbr_pkg::REG_ORDER_ID:      regs_q.order_robot_id      <= cfg_word.value;
				cbr_pkg::REG_HB_TIMEOUT:    regs_q.heartbeat_timeout   <= cfg_word.value[3:0];
				cbr_pkg::REG_STABLE_THRESH: regs_q.stable_threshold    <= cfg_word.value[4:0];
				cbr_pkg::REG_HB_ENABLE:     regs_q.heartbeat_enable    <= cfg_word.value[0];
				default: begin
				end
			endcase
		end
	end

	// the input stage moves on whenever the result register is free or draining
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.data;
		end
	end

	cbr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.regs   (regs_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = res_q;

endmodule
`default_nettype wire

// ===== rtl/cbr_engine.sv =====
`default_nettype none
module cbr_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire cbr_pkg::cbr_in_t  item,
	input  wire cbr_pkg::cbr_regs_t regs,
	output cbr_pkg::cbr_out_t      res
);

	logic       alive_q, role_m_q, role_s_q, stable_q, last_q;
	logic [3:0] tc_q;
	logic [4:0] sc_q;
	logic [5:0] lc_q;

	logic       n_alive, n_role_m, n_role_s, n_stable, n_last;
	logic [3:0] n_tc;
	logic [4:0] n_sc;
	logic [5:0] n_lc;
	logic [4:0] sc_inc;
	logic [10:0] base_sel;
	logic       hit_master, hit_slave;

	assign hit_master = (item.frame_id & cbr_pkg::MASTER_MASK) ==
		(regs.master_robot_base & cbr_pkg::MASTER_MASK);
	assign hit_slave = (item.frame_id & cbr_pkg::SLAVE_MASK) ==
		(regs.slave_robot_base & cbr_pkg::SLAVE_MASK);
	// bridge ids 0x18..0x1f map back to slaves, 0x10..0x17 to masters
	assign base_sel = item.frame_id[3] ? regs.slave_robot_base : regs.master_robot_base;
	assign sc_inc = (sc_q != 5'd31) ? sc_q + 5'd1 : sc_q;

	always_comb begin
		res      = '0;
		n_alive  = alive_q;
		n_role_m = role_m_q;
		n_role_s = role_s_q;
		n_stable = stable_q;
		n_last   = last_q;
		n_tc     = tc_q;
		n_sc     = sc_q;
		n_lc     = lc_q;
		case (item.cmd)
			cbr_pkg::CMD_ROBOT: begin
				res.out_port = 1'b1;
				res.out_dlc  = item.frame_dlc;
				if (item.frame_id == regs.lock_order_robot_id) begin
					res.send_valid = 1'b1;
					res.out_id     = cbr_pkg::BR_LOCK;
				end else if (hit_master) begin
					n_role_m       = 1'b1;
					res.send_valid = 1'b1;
					res.out_id     = cbr_pkg::BR_MASTER | {9'd0, item.frame_id[1:0]};
				end else if (hit_slave) begin
					n_role_s       = 1'b1;
					res.send_valid = 1'b1;
					res.out_id     = cbr_pkg::BR_SLAVE | {10'd0, item.frame_id[0]};
				end else if (item.frame_id == regs.order_robot_id) begin
					res.send_valid = 1'b1;
					res.out_id     = cbr_pkg::BR_ORDER;
				end
				if (!res.send_valid) begin
					res.out_port = 1'b0;
					res.out_dlc  = '0;
				end
			end
			cbr_pkg::CMD_ADAPTER: begin
				if ((item.frame_id & cbr_pkg::BR_BLOCK_MASK) == cbr_pkg::BR_MASTER) begin
					res.send_valid = 1'b1;
					res.out_dlc    = item.frame_dlc;
					res.out_id     = base_sel + {8'd0, item.frame_id[2:0]};
				end else if ((item.frame_id & cbr_pkg::BR_BLOCK_MASK) == cbr_pkg::BR_LOCK) begin
					res.send_valid = 1'b1;
					res.out_dlc    = item.frame_dlc;
					res.out_id     = item.frame_id[3] ? regs.order_robot_id
						: regs.lock_order_robot_id;
				end else if ((item.frame_id & cbr_pkg::SLAVE_MASK) == cbr_pkg::HB_MASTER_ID) begin
					// peer heartbeat
					n_alive = 1'b1;
					n_tc    = '0;
					if (sc_inc >= regs.stable_threshold) begin
						n_stable = 1'b1;
						n_sc     = cbr_pkg::STABLE_RELOAD;
					end else begin
						n_sc = sc_inc;
					end
					if (item.role_byte_master == 8'd1 && item.role_byte_slave == 8'd0) begin
						n_role_m = 1'b0;
						n_role_s = 1'b1;
					end else if (item.role_byte_master == 8'd0 &&
						item.role_byte_slave == 8'd1) begin
						n_role_m = 1'b1;
						n_role_s = 1'b0;
					end
				end
			end
			cbr_pkg::CMD_TICK: begin
				if (alive_q) begin
					n_tc = (tc_q != 4'd15) ? tc_q + 4'd1 : tc_q;
					if (!stable_q) begin
						n_lc = (lc_q != 6'd63) ? lc_q + 6'd1 : lc_q;
						if ({1'b0, n_lc} >= {2'b00, n_sc} + cbr_pkg::LOST_MARGIN) begin
							n_lc = '0;
							n_sc = '0;
						end
					end
					if (n_tc >= regs.heartbeat_timeout) begin
						n_alive  = 1'b0;
						n_role_m = 1'b0;
						n_role_s = 1'b0;
						n_tc     = '0;
						n_lc     = '0;
						n_sc     = '0;
						n_stable = 1'b0;
					end
				end
				if (n_role_m != n_role_s) begin
					n_alive         = 1'b1;
					res.send_valid  = 1'b1;
					res.out_port    = 1'b1;
					res.out_id      = n_role_m ? cbr_pkg::HB_MASTER_ID : cbr_pkg::HB_SLAVE_ID;
					res.out_dlc     = cbr_pkg::HB_DLC;
					res.hb_enabled  = regs.heartbeat_enable;
					res.hb_received = 1'b1;
					res.hb_master   = n_role_m;
					res.hb_slave    = n_role_s;
					res.hb_timeout  = n_tc;
				end
				if (last_q != n_alive) begin
					n_last         = n_alive;
					res.link_event = n_alive ? cbr_pkg::LINK_DETECTED : cbr_pkg::LINK_LOST;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q  <= 1'b0;
			role_m_q <= 1'b0;
			role_s_q <= 1'b0;
			stable_q <= 1'b0;
			last_q   <= 1'b0;
			tc_q     <= '0;
			sc_q     <= '0;
			lc_q     <= '0;
		end else if (en) begin
			alive_q  <= n_alive;
			role_m_q <= n_role_m;
			role_s_q <= n_role_s;
			stable_q <= n_stable;
			last_q   <= n_last;
			tc_q     <= n_tc;
			sc_q     <= n_sc;
			lc_q     <= n_lc;
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb_can_bridge_id_remap_heartbeat_unit.sv =====
`timescale 1ns / 1ps
import cbr_pkg::*;

class bridge_scoreboard;
	cbr_regs_t   regs;
	logic        link_alive, role_master, role_slave, conn_stable, reported_alive;
	logic [3:0]  hb_age;
	logic [4:0]  stable_cnt;
	logic [5:0]  lost_cnt;
	cbr_out_t    outgoing_q[$];
	int          mismatches, words_in, frames_sent, hb_sent, link_events;

	function new();
		regs = '{RST_MASTER_BASE, RST_SLAVE_BASE, RST_LOCK_ID, RST_ORDER_ID,
			RST_HB_TIMEOUT, RST_STABLE_THRESH, RST_HB_ENABLE};
		link_alive = 1'b0;
		role_master = 1'b0;
		role_slave = 1'b0;
		conn_stable = 1'b0;
		reported_alive = 1'b0;
		hb_age = '0;
		stable_cnt = '0;
		lost_cnt = '0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [10:0] val);
		case (idx)
		REG_MASTER_BASE:   regs.master_robot_base = val;
		REG_SLAVE_BASE:    regs.slave_robot_base = val;
		REG_LOCK_ID:       regs.lock_order_robot_id = val;
		REG_ORDER_ID:      regs.order_robot_id = val;
		REG_HB_TIMEOUT:    regs.heartbeat_timeout = val[3:0];
		REG_STABLE_THRESH: regs.stable_threshold = val[4:0];
		REG_HB_ENABLE:     regs.heartbeat_enable = val[0];
		default: ;
		endcase
	endfunction

	function cbr_out_t frame_out(logic port, logic [10:0] id, logic [3:0] dlc);
		cbr_out_t r;
		r = '0;
		r.send_valid = 1'b1;
		r.out_port = port;
		r.out_id = id;
		r.out_dlc = dlc;
		return r;
	endfunction

	function void peer_heartbeat(logic [7:0] bm, logic [7:0] bs);
		link_alive = 1'b1;
		if (stable_cnt != 5'd31)
			stable_cnt++;
		hb_age = '0;
		if (stable_cnt >= regs.stable_threshold) begin
			conn_stable = 1'b1;
			stable_cnt = STABLE_RELOAD;
		end
		if (bm == 8'd1 && bs == 8'd0) begin
			role_master = 1'b0;
			role_slave = 1'b1;
		end else if (bm == 8'd0 && bs == 8'd1) begin
			role_master = 1'b1;
			role_slave = 1'b0;
		end
	endfunction

	// one result word per input word, state advanced in place
	function cbr_out_t remap_word(cbr_in_t w);
		cbr_out_t    r;
		logic [10:0] id;
		r = '0;
		id = w.frame_id;
		case (w.cmd)
		CMD_ROBOT: begin
			if (id == regs.lock_order_robot_id)
				r = frame_out(1'b1, BR_LOCK, w.frame_dlc);
			else if ((id & MASTER_MASK) == (regs.master_robot_base & MASTER_MASK)) begin
				role_master = 1'b1;
				r = frame_out(1'b1, BR_MASTER + {9'd0, id[1:0]}, w.frame_dlc);
			end else if ((id & SLAVE_MASK) == (regs.slave_robot_base & SLAVE_MASK)) begin
				role_slave = 1'b1;
				r = frame_out(1'b1, BR_SLAVE + {10'd0, id[0]}, w.frame_dlc);
			end else if (id == regs.order_robot_id)
				r = frame_out(1'b1, BR_ORDER, w.frame_dlc);
		end
		CMD_ADAPTER: begin
			// bit 3 selects the upper half of each bridge block
			if ((id & BR_BLOCK_MASK) == BR_MASTER) begin
				if (id[3])
					r = frame_out(1'b0, regs.slave_robot_base + id - BR_SLAVE, w.frame_dlc);
				else
					r = frame_out(1'b0, regs.master_robot_base + id - BR_MASTER, w.frame_dlc);
			end else if ((id & BR_BLOCK_MASK) == BR_LOCK) begin
				if (id[3])
					r = frame_out(1'b0, regs.order_robot_id, w.frame_dlc);
				else
					r = frame_out(1'b0, regs.lock_order_robot_id, w.frame_dlc);
			end else if ((id & SLAVE_MASK) == HB_MASTER_ID)
				peer_heartbeat(w.role_byte_master, w.role_byte_slave);
		end
		CMD_TICK: begin
			if (link_alive) begin
				if (hb_age != 4'd15)
					hb_age++;
				if (!conn_stable) begin
					if (lost_cnt != 6'd63)
						lost_cnt++;
					if (int'(lost_cnt) - int'(stable_cnt) >= int'(LOST_MARGIN)) begin
						lost_cnt = '0;
						stable_cnt = '0;
					end
				end
				if (hb_age >= regs.heartbeat_timeout) begin
					link_alive = 1'b0;
					role_master = 1'b0;
					role_slave = 1'b0;
					hb_age = '0;
					lost_cnt = '0;
					stable_cnt = '0;
					conn_stable = 1'b0;
				end
			end
			if (role_master != role_slave) begin
				link_alive = 1'b1;
				r = frame_out(1'b1, role_master ? HB_MASTER_ID : HB_SLAVE_ID, HB_DLC);
				r.hb_enabled = regs.heartbeat_enable;
				r.hb_received = link_alive;
				r.hb_master = role_master;
				r.hb_slave = role_slave;
				r.hb_timeout = hb_age;
				hb_sent++;
			end
			if (reported_alive != link_alive) begin
				reported_alive = link_alive;
				r.link_event = link_alive ? LINK_DETECTED : LINK_LOST;
				link_events++;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function void note_word(cbr_in_t w);
		cbr_out_t r;
		r = remap_word(w);
		words_in++;
		if (r.send_valid)
			frames_sent++;
		outgoing_q.push_back(r);
	endfunction

	function void check_field(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			mismatches++;
			$display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
		end
	endfunction

	function void check_word(cbr_out_t got);
		cbr_out_t exp_w;
		if (outgoing_q.size() == 0) begin
			mismatches++;
			$display("%0t: result word expected none got %h", $time, got);
			return;
		end
		exp_w = outgoing_q.pop_front();
		check_field("send_valid", exp_w.send_valid, got.send_valid);
		check_field("out_port", exp_w.out_port, got.out_port);
		check_field("out_id", exp_w.out_id, got.out_id);
		check_field("out_dlc", exp_w.out_dlc, got.out_dlc);
		check_field("hb_enabled", exp_w.hb_enabled, got.hb_enabled);
		check_field("hb_received", exp_w.hb_received, got.hb_received);
		check_field("hb_master", exp_w.hb_master, got.hb_master);
		check_field("hb_slave", exp_w.hb_slave, got.hb_slave);
		check_field("hb_timeout", exp_w.hb_timeout, got.hb_timeout);
		check_field("link_event", exp_w.link_event, got.link_event);
	endfunction
endclass

module tb_can_bridge_id_remap_heartbeat_unit;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int PHASE_WORDS = 132;
	localparam int LONG_HOLD = 120;

	logic clk;
	logic arst_n;
	bit   long_hold_req;
	int   src_idle_pct;
	int   sink_idle_pct;
	int   n_settings;

	bridge_scoreboard bridge_sb = new();

	cbr_stream_if #(.payload_t(cbr_in_t))  in_ch ();
	cbr_stream_if #(.payload_t(cbr_out_t)) out_ch ();
	cbr_stream_if #(.payload_t(cbr_cfg_t)) cfg_ch ();

	can_bridge_id_remap_heartbeat_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			bridge_sb.check_word(out_ch.data);
	end

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && $urandom_range(0, 99) < sink_idle_pct)
				stall_left = idle_len();
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	task automatic push_word(input cbr_in_t w);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (idle_len() - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
		bridge_sb.note_word(w);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= {idx, val};
		do @(posedge clk); while (!cfg_ch.ready);
		bridge_sb.set_reg(idx, val);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic load_settings(input cbr_regs_t r);
		write_reg(REG_MASTER_BASE, r.master_robot_base);
		write_reg(REG_SLAVE_BASE, r.slave_robot_base);
		write_reg(REG_LOCK_ID, r.lock_order_robot_id);
		write_reg(REG_ORDER_ID, r.order_robot_id);
		write_reg(REG_HB_TIMEOUT, {7'd0, r.heartbeat_timeout});
		write_reg(REG_STABLE_THRESH, {6'd0, r.stable_threshold});
		write_reg(REG_HB_ENABLE, {10'd0, r.heartbeat_enable});
		n_settings++;
	endtask

	// stop offering, let every pending result drain, then cover the pipeline depth
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (bridge_sb.outgoing_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic cbr_in_t word_of(logic [1:0] c, logic [10:0] id, logic [3:0] dlc,
			logic [7:0] bm, logic [7:0] bs);
		return {c, id, dlc, bm, bs};
	endfunction

	task automatic run_directed();
		push_word(word_of(CMD_ROBOT, 11'd137, 4'd0, 8'h00, 8'h00));
		push_word(word_of(CMD_ROBOT, 11'd292, 4'd15, 8'h00, 8'h00));
		push_word(word_of(CMD_ROBOT, 11'd295, 4'd8, 8'h00, 8'h00));
		push_word(word_of(CMD_ROBOT, 11'd266, 4'd1, 8'h00, 8'h00));
		push_word(word_of(CMD_ROBOT, 11'd267, 4'd2, 8'h00, 8'h00));
		push_word(word_of(CMD_ROBOT, 11'd368, 4'd7, 8'h00, 8'h00));
		push_word(word_of(CMD_ROBOT, 11'd0, 4'd0, 8'h00, 8'h00));
		push_word(word_of(CMD_ROBOT, 11'h7FF, 4'd15, 8'hFF, 8'hFF));
		// both roles held: no heartbeat goes out
		push_word(word_of(CMD_TICK, 11'd0, 4'd0, 8'h00, 8'h00));
		push_word(word_of(CMD_ADAPTER, 11'h010, 4'd3, 8'h00, 8'h00));
		push_word(word_of(CMD_ADAPTER, 11'h017, 4'd4, 8'h00, 8'h00));
		push_word(word_of(CMD_ADAPTER, 11'h018, 4'd5, 8'h00, 8'h00));
		push_word(word_of(CMD_ADAPTER, 11'h01F, 4'd6, 8'h00, 8'h00));
		push_word(word_of(CMD_ADAPTER, 11'h020, 4'd9, 8'h00, 8'h00));
		push_word(word_of(CMD_ADAPTER, 11'h027, 4'd10, 8'h00, 8'h00));
		push_word(word_of(CMD_ADAPTER, 11'h028, 4'd11, 8'h00, 8'h00));
		push_word(word_of(CMD_ADAPTER, 11'h02F, 4'd15, 8'h00, 8'h00));
		push_word(word_of(CMD_ADAPTER, HB_MASTER_ID, 4'd5, 8'd1, 8'd0));
		push_word(word_of(CMD_TICK, 11'd0, 4'd0, 8'h00, 8'h00));
		push_word(word_of(CMD_ADAPTER, HB_SLAVE_ID, 4'd5, 8'd0, 8'd1));
		push_word(word_of(CMD_ADAPTER, HB_MASTER_ID, 4'd5, 8'hFF, 8'hFF));
		push_word(word_of(CMD_TICK, 11'h7FF, 4'd15, 8'hFF, 8'hFF));
		push_word(word_of(CMD_ADAPTER, 11'h7FF, 4'd15, 8'hAA, 8'h55));
		push_word(word_of(CMD_UNUSED, 11'h7FF, 4'd15, 8'hFF, 8'hFF));
		push_word(word_of(CMD_TICK, 11'd0, 4'd0, 8'h00, 8'h00));
	endtask

	function automatic cbr_in_t gen_word(int hb_w);
		cbr_in_t w;
		int      roll;
		w = {2'($urandom), 11'($urandom), 4'($urandom), 8'($urandom), 8'($urandom)};
		roll = $urandom_range(0, 99);
		if (roll < 30)
			w.cmd = CMD_TICK;
		else if (roll < 30 + hb_w) begin
			w.cmd = CMD_ADAPTER;
			w.frame_id = HB_MASTER_ID | 11'($urandom_range(0, 1));
			case ($urandom_range(0, 4))
			0, 1: {w.role_byte_master, w.role_byte_slave} = {8'd1, 8'd0};
			2, 3: {w.role_byte_master, w.role_byte_slave} = {8'd0, 8'd1};
			default: ;
			endcase
		end else if (roll < 72) begin
			w.cmd = CMD_ROBOT;
			case ($urandom_range(0, 5))
			0: w.frame_id = bridge_sb.regs.lock_order_robot_id;
			1: w.frame_id = bridge_sb.regs.order_robot_id;
			2: w.frame_id = {bridge_sb.regs.master_robot_base[10:2], 2'($urandom)};
			3: w.frame_id = {bridge_sb.regs.slave_robot_base[10:1], 1'($urandom)};
			4: w.frame_id = bridge_sb.regs.master_robot_base + 11'($urandom_range(0, 9)) - 11'd3;
			default: ;
			endcase
		end else if (roll < 92) begin
			w.cmd = CMD_ADAPTER;
			w.frame_id = BR_MASTER + 11'($urandom_range(0, 31));
		end else if (roll < 97)
			w.cmd = 2'($urandom_range(0, 2));
		else
			w.cmd = CMD_UNUSED;
		return w;
	endfunction

	task automatic run_random(input int n, input bit hold_out, input bit mid_pause);
		int hb_w;
		hb_w = $urandom_range(4, 30);
		if ($urandom_range(0, 3) == 0 || hold_out) begin
			src_idle_pct = 0;
			sink_idle_pct = hold_out ? $urandom_range(10, 40) : 0;
		end else begin
			src_idle_pct = $urandom_range(10, 50);
			sink_idle_pct = $urandom_range(10, 50);
		end
		if (hold_out)
			long_hold_req = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (mid_pause && i == n / 2)
				settle();
			push_word(gen_word(hb_w));
		end
	endtask

	function automatic cbr_regs_t random_settings();
		cbr_regs_t   r;
		logic [10:0] hub;
		hub = 11'($urandom);
		r.master_robot_base = 11'($urandom);
		r.slave_robot_base = 11'($urandom);
		r.lock_order_robot_id = 11'($urandom);
		r.order_robot_id = 11'($urandom);
		// clustered ids so the filters overlap
		if ($urandom_range(0, 1) == 1) begin
			r.master_robot_base = hub + 11'($urandom_range(0, 7));
			r.slave_robot_base = hub + 11'($urandom_range(0, 7));
			r.lock_order_robot_id = hub + 11'($urandom_range(0, 7));
			r.order_robot_id = hub + 11'($urandom_range(0, 7));
		end
		r.heartbeat_timeout = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15))
			: 4'($urandom_range(1, 4));
		r.stable_threshold = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(7, 31))
			: 5'($urandom_range(1, 6));
		r.heartbeat_enable = 1'($urandom);
		return r;
	endfunction

	initial begin : stimulus
		int wait_cycles;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		long_hold_req = 1'b0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		n_settings = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_random(PHASE_WORDS, 1'b1, 1'b0);

		settle();
		load_settings('{11'd0, 11'd0, 11'd0, 11'd0, 4'd1, 5'd1, 1'b0});
		run_random(PHASE_WORDS, 1'b0, 1'b1);
		settle();
		load_settings('{11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 4'd15, 5'd31, 1'b1});
		run_random(PHASE_WORDS, 1'b0, 1'b0);
		settle();
		// unaligned bases with lock and order inside the master group
		load_settings('{11'h041, 11'h043, 11'h042, 11'h040, 4'd3, 5'd2, 1'b1});
		run_random(PHASE_WORDS, 1'b1, 1'b0);
		settle();
		// zero timeout drops an alive link on its first tick
		load_settings('{11'h3A5, 11'h5C3, 11'h201, 11'h202, 4'd0, 5'd5, 1'b1});
		run_random(PHASE_WORDS, 1'b0, 1'b0);
		for (int p = 0; p < 6; p++) begin
			settle();
			load_settings(random_settings());
			run_random(PHASE_WORDS, p == 2, p == 4);
		end

		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait_cycles = 0;
		while (bridge_sb.outgoing_q.size() != 0 && wait_cycles < 10000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (4) @(posedge clk);
		if (bridge_sb.outgoing_q.size() != 0) begin
			bridge_sb.mismatches += bridge_sb.outgoing_q.size();
			$display("%0t: %0d result words never arrived", $time, bridge_sb.outgoing_q.size());
		end
		$display("ran %0d words under %0d register settings", bridge_sb.words_in, n_settings);
		$display("frames sent %0d, heartbeat frames %0d, link changes %0d",
			bridge_sb.frames_sent, bridge_sb.hb_sent, bridge_sb.link_events);
		if (bridge_sb.mismatches == 0)
			$display("tb_can_bridge_id_remap_heartbeat_unit OK");
		else
			$display("tb_can_bridge_id_remap_heartbeat_unit NOT OK");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("tb_can_bridge_id_remap_heartbeat_unit NOT OK");
		$finish;
	end
endmodule
